@@ design/psdc_pkg.sv @@
// Shared types, constants and the microprogram of the PID step unit.
// Used by the sequencer, the datapath, the multiplier and the top level.
package psdc_pkg;

    localparam int PC_W      = 5;
    localparam int TERM_W    = 62;  // signed product term, magnitude up to 2^60
    localparam int TERM_LOG  = 60;
    localparam int SUM_W     = 64;  // base plus three terms always fits
    localparam int MUL_DIG   = 16;  // multiplier digit width
    localparam int CFG_IDX_W = 3;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_IN    = 3'd2,
        C_MUL_BUSY = 3'd3,
        C_OUT_FREE = 3'd4
    } t_cond;

    typedef enum logic [1:0] {
        M_NONE  = 2'd0,
        M_START = 2'd1,
        M_MAC   = 2'd2
    } t_mul_op;

    typedef enum logic [1:0] {
        A_ERR   = 2'd0,
        A_DIFF  = 2'd1,
        A_INTEG = 2'd2,
        A_DERIV = 2'd3
    } t_asel;

    typedef enum logic [2:0] {
        B_GP   = 3'd0,
        B_GI   = 3'd1,
        B_GD   = 3'd2,
        B_RATE = 3'd3,
        B_TIME = 3'd4
    } t_bsel;

    typedef enum logic [1:0] {
        D_NONE  = 2'd0,
        D_SUM   = 2'd1,
        D_DERIV = 2'd2,
        D_INTEG = 2'd3
    } t_dst;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_OUT_MAX   = 3'd3,
        CFG_OUT_MIN   = 3'd4,
        CFG_STEP_TIME = 3'd5,
        CFG_STEP_RATE = 3'd6,
        CFG_DEAD_ZONE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic    accept;
        logic    diff;
        t_mul_op mul_op;
        t_asel   a_sel;
        t_bsel   b_sel;
        logic    fin;
        t_dst    dst;
        logic    emit;
        t_cond   cond;
        t_pc     target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic mul_busy;
        logic out_free;
    } t_stat;

    // Program step labels.
    localparam t_pc S_WAIT  = 5'd0;
    localparam t_pc S_DIFF  = 5'd1;
    localparam t_pc S_MAC_P = 5'd2;
    localparam t_pc S_FIN_P = 5'd3;
    localparam t_pc S_ADD_P = 5'd4;
    localparam t_pc S_MAC_R = 5'd5;
    localparam t_pc S_FIN_R = 5'd6;
    localparam t_pc S_DER   = 5'd7;
    localparam t_pc S_MAC_I = 5'd8;
    localparam t_pc S_FIN_I = 5'd9;
    localparam t_pc S_ADD_I = 5'd10;
    localparam t_pc S_MAC_D = 5'd11;
    localparam t_pc S_FIN_D = 5'd12;
    localparam t_pc S_ADD_D = 5'd13;
    localparam t_pc S_MAC_T = 5'd14;
    localparam t_pc S_FIN_T = 5'd15;
    localparam t_pc S_INTEG = 5'd16;
    localparam t_pc S_EMIT  = 5'd17;
    localparam t_pc S_BACK  = 5'd18;

    // Control store. A step whose condition holds jumps to its target,
    // otherwise the step counter advances by one.
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        begin
            w        = '0;
            w.mul_op = M_NONE;
            w.a_sel  = A_ERR;
            w.b_sel  = B_GP;
            w.dst    = D_NONE;
            w.cond   = C_NEVER;
            w.target = S_WAIT;
            case (pc)
                S_WAIT: begin
                    w.accept = 1'b1;
                    w.cond   = C_NO_IN;
                    w.target = S_WAIT;
                end
                S_DIFF: begin
                    w.diff   = 1'b1;
                    w.mul_op = M_START;
                    w.a_sel  = A_ERR;
                    w.b_sel  = B_GP;
                end
                S_MAC_P: begin
                    w.mul_op = M_MAC;
                    w.cond   = C_MUL_BUSY;
                    w.target = S_MAC_P;
                end
                S_FIN_P: w.fin = 1'b1;
                S_ADD_P: begin
                    w.dst    = D_SUM;
                    w.mul_op = M_START;
                    w.a_sel  = A_DIFF;
                    w.b_sel  = B_RATE;
                end
                S_MAC_R: begin
                    w.mul_op = M_MAC;
                    w.cond   = C_MUL_BUSY;
                    w.target = S_MAC_R;
                end
                S_FIN_R: w.fin = 1'b1;
                S_DER: begin
                    w.dst    = D_DERIV;
                    w.mul_op = M_START;
                    w.a_sel  = A_INTEG;
                    w.b_sel  = B_GI;
                end
                S_MAC_I: begin
                    w.mul_op = M_MAC;
                    w.cond   = C_MUL_BUSY;
                    w.target = S_MAC_I;
                end
                S_FIN_I: w.fin = 1'b1;
                S_ADD_I: begin
                    w.dst    = D_SUM;
                    w.mul_op = M_START;
                    w.a_sel  = A_DERIV;
                    w.b_sel  = B_GD;
                end
                S_MAC_D: begin
                    w.mul_op = M_MAC;
                    w.cond   = C_MUL_BUSY;
                    w.target = S_MAC_D;
                end
                S_FIN_D: w.fin = 1'b1;
                S_ADD_D: begin
                    w.dst    = D_SUM;
                    w.mul_op = M_START;
                    w.a_sel  = A_ERR;
                    w.b_sel  = B_TIME;
                end
                S_MAC_T: begin
                    w.mul_op = M_MAC;
                    w.cond   = C_MUL_BUSY;
                    w.target = S_MAC_T;
                end
                S_FIN_T: w.fin = 1'b1;
                S_INTEG: w.dst = D_INTEG;
                S_EMIT: begin
                    w.emit   = 1'b1;
                    w.cond   = C_OUT_FREE;
                    w.target = S_WAIT;
                end
                S_BACK: begin
                    w.cond   = C_ALWAYS;
                    w.target = S_EMIT;
                end
                default: begin
                    w.cond   = C_ALWAYS;
                    w.target = S_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

@@ design/psdc_seq.sv @@
// Step counter and control store lookup of the PID step unit.
// Depends on psdc_pkg for the control word, status and program.
module psdc_seq
    import psdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w;
    logic  take;

    always_comb begin
        w = ucode(r_pc);
        case (w.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_stat.in_valid;
            C_MUL_BUSY: take = i_stat.mul_busy;
            C_OUT_FREE: take = i_stat.out_free;
            default:    take = 1'b0;
        endcase
        n_pc = take ? w.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w;

endmodule

@@ design/psdc_mul.sv @@
// Shared sign-magnitude multiplier: one 16-bit digit of B per cycle, then
// a scale, saturate and sign step. Depends on psdc_pkg.
module psdc_mul
    import psdc_pkg::*;
#(
    parameter int AW   = 48,
    parameter int BW   = 32,
    parameter int FRAC = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic                     o_busy,
    output logic signed [TERM_W-1:0] o_term
);

    localparam int ND  = (BW + MUL_DIG - 1) / MUL_DIG;
    localparam int BPW = ND * MUL_DIG;
    localparam int PW  = AW + BPW;
    localparam int SW  = (PW > TERM_W) ? PW : TERM_W;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;
    localparam logic [SW-1:0] LIMIT = SW'(1) << TERM_LOG;

    logic [AW-1:0]           r_amag;
    logic [BPW-1:0]          r_bmag;
    logic                    r_neg;
    logic [PW-1:0]           r_acc;
    logic [CW-1:0]           r_cnt;
    logic signed [TERM_W-1:0] r_term;

    logic [AW-1:0]          a_mag;
    logic [BW-1:0]          b_mag;
    logic [AW+MUL_DIG-1:0]  prod;
    logic [PW-1:0]          shifted;
    logic [SW-1:0]          ext;
    logic [TERM_W-1:0]      mag_t;

    always_comb begin
        a_mag   = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
        b_mag   = i_b[BW-1] ? (~i_b + 1'b1) : i_b;
        prod    = r_amag * r_bmag[BPW-1 -: MUL_DIG];
        shifted = r_acc >> FRAC;
        ext     = SW'(shifted);
        mag_t   = (ext > LIMIT) ? LIMIT[TERM_W-1:0] : ext[TERM_W-1:0];
    end

    // Digits are taken from the top, so the accumulator shifts left each step.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_op == M_START) begin
            r_amag <= a_mag;
            r_bmag <= BPW'(b_mag);
            r_neg  <= i_a[AW-1] ^ i_b[BW-1];
            r_acc  <= '0;
        end else if (i_ctrl.mul_op == M_MAC) begin
            r_acc  <= (r_acc << MUL_DIG) + PW'(prod);
            r_bmag <= r_bmag << MUL_DIG;
        end
        if (i_ctrl.fin) begin
            r_term <= r_neg ? signed'(~mag_t + 1'b1) : signed'(mag_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.mul_op == M_START) begin
            r_cnt <= '0;
        end else if (i_ctrl.mul_op == M_MAC) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = (r_cnt != CW'(ND - 1));
    assign o_term = r_term;

endmodule

@@ design/psdc_dpath.sv @@
// Datapath of the PID step unit: deadband, operand selection, term
// accumulation, derivative and integral saturation, output clamp.
// Depends on psdc_pkg and psdc_mul.
module psdc_dpath
    import psdc_pkg::*;
#(
    parameter int DW   = 32,
    parameter int FRAC = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic                 i_in_valid,
    input  logic signed [DW-1:0] i_error,
    input  logic signed [DW-1:0] i_base,
    input  logic signed [DW-1:0] i_gain_p,
    input  logic signed [DW-1:0] i_gain_i,
    input  logic signed [DW-1:0] i_gain_d,
    input  logic signed [DW-1:0] i_out_max,
    input  logic signed [DW-1:0] i_out_min,
    input  logic [DW-2:0]        i_step_time,
    input  logic [DW-2:0]        i_step_rate,
    input  logic [DW-2:0]        i_dead_zone,
    output logic                 o_mul_busy,
    output logic signed [DW-1:0] o_drive
);

    localparam int IW  = DW + 16;
    localparam int IAW = ((IW > TERM_W) ? IW : TERM_W) + 1;
    localparam logic signed [SUM_W-1:0] D_HI = {{(SUM_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] D_LO = ~D_HI;
    localparam logic signed [IAW-1:0]   I_HI = {{(IAW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [IAW-1:0]   I_LO = ~I_HI;

    logic signed [DW-1:0]    r_e;
    logic signed [DW-1:0]    r_last;
    logic signed [DW:0]      r_diff;
    logic signed [DW-1:0]    r_deriv;
    logic signed [IW-1:0]    r_integ;
    logic signed [SUM_W-1:0] r_sum;

    logic [DW-1:0]           err_mag;
    logic signed [DW-1:0]    e_db;
    logic signed [IW-1:0]    op_a;
    logic signed [DW-1:0]    op_b;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0] term64;
    logic signed [IAW-1:0]   isum;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] clamp_hi;
    logic signed [SUM_W-1:0] clamp_lo;

    psdc_mul #(
        .AW   (IW),
        .BW   (DW),
        .FRAC (FRAC)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (i_ctrl),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_busy  (o_mul_busy),
        .o_term  (term)
    );

    always_comb begin
        // The most negative error has magnitude 2^(DW-1), which fits unsigned.
        err_mag = i_error[DW-1] ? (~i_error + 1'b1) : i_error;
        e_db    = (err_mag <= {1'b0, i_dead_zone}) ? '0 : i_error;

        case (i_ctrl.a_sel)
            A_ERR:   op_a = IW'(r_e);
            A_DIFF:  op_a = IW'(r_diff);
            A_INTEG: op_a = r_integ;
            A_DERIV: op_a = IW'(r_deriv);
            default: op_a = '0;
        endcase

        case (i_ctrl.b_sel)
            B_GP:    op_b = i_gain_p;
            B_GI:    op_b = i_gain_i;
            B_GD:    op_b = i_gain_d;
            B_RATE:  op_b = signed'({1'b0, i_step_rate});
            B_TIME:  op_b = signed'({1'b0, i_step_time});
            default: op_b = '0;
        endcase

        term64   = SUM_W'(term);
        isum     = IAW'(r_integ) + IAW'(term);

        hi       = SUM_W'(i_out_max);
        lo       = SUM_W'(i_out_min);
        clamp_hi = (r_sum > hi) ? hi : r_sum;
        clamp_lo = (clamp_hi < lo) ? lo : clamp_hi;
        o_drive  = clamp_lo[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && i_in_valid) begin
            r_e   <= e_db;
            r_sum <= SUM_W'(i_base);
        end else if (i_ctrl.dst == D_SUM) begin
            r_sum <= r_sum + term64;
        end
        if (i_ctrl.diff) begin
            r_diff <= (DW+1)'(r_e) - (DW+1)'(r_last);
        end
        if (i_ctrl.dst == D_DERIV) begin
            if (term64 > D_HI) begin
                r_deriv <= D_HI[DW-1:0];
            end else if (term64 < D_LO) begin
                r_deriv <= D_LO[DW-1:0];
            end else begin
                r_deriv <= term64[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_ctrl.dst == D_INTEG) begin
            r_last <= r_e;
            if (isum > I_HI) begin
                r_integ <= I_HI[IW-1:0];
            end else if (isum < I_LO) begin
                r_integ <= I_LO[IW-1:0];
            end else begin
                r_integ <= isum[IW-1:0];
            end
        end
    end

endmodule

@@ design/pid_step_deadband_clamp_unit.sv @@
// PID step unit with deadband and output clamp, signed fixed point.
// Input words are taken one at a time: a new word is accepted only after the
// previous result has been written to the output register, since the five
// products share one 16-bit-digit multiplier under the microprogram.
// Synchronous active-low reset clears the integral, the previous error and all
// configuration registers to their defaults.
module pid_step_deadband_clamp_unit
    import psdc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // error_in, base_value, zero fill
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // drive_out, zero fill
    output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    input  logic                                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                     i_cfg_index,
    input  logic [DATA_WIDTH-1:0]                    i_cfg_wdata
);

    localparam int DW  = DATA_WIDTH;
    localparam int ODW = ((DW + 7) / 8) * 8;

    logic signed [DW-1:0] r_gain_p;
    logic signed [DW-1:0] r_gain_i;
    logic signed [DW-1:0] r_gain_d;
    logic signed [DW-1:0] r_out_max;
    logic signed [DW-1:0] r_out_min;
    logic [DW-2:0]        r_step_time;
    logic [DW-2:0]        r_step_rate;
    logic [DW-2:0]        r_dead_zone;
    logic                 r_out_valid;
    logic [DW-1:0]        r_out_data;

    t_ctrl                ctrl;
    t_stat                stat;
    logic                 mul_busy;
    logic                 out_free;
    logic signed [DW-1:0] drive;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign stat.in_valid = s_axis_tvalid;
    assign stat.mul_busy = mul_busy;
    assign stat.out_free = out_free;

    psdc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    psdc_dpath #(
        .DW   (DW),
        .FRAC (FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (s_axis_tvalid),
        .i_error     (signed'(s_axis_tdata[DW-1:0])),
        .i_base      (signed'(s_axis_tdata[2*DW-1:DW])),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_out_max   (r_out_max),
        .i_out_min   (r_out_min),
        .i_step_time (r_step_time),
        .i_step_rate (r_step_rate),
        .i_dead_zone (r_dead_zone),
        .o_mul_busy  (mul_busy),
        .o_drive     (drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_out_max   <= {1'b0, {(DW-1){1'b1}}};
            r_out_min   <= {1'b1, {(DW-1){1'b0}}};
            r_step_time <= (DW-1)'(1) << FRAC_BITS;
            r_step_rate <= (DW-1)'(1) << FRAC_BITS;
            r_dead_zone <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_P:    r_gain_p    <= i_cfg_wdata;
                CFG_GAIN_I:    r_gain_i    <= i_cfg_wdata;
                CFG_GAIN_D:    r_gain_d    <= i_cfg_wdata;
                CFG_OUT_MAX:   r_out_max   <= i_cfg_wdata;
                CFG_OUT_MIN:   r_out_min   <= i_cfg_wdata;
                CFG_STEP_TIME: r_step_time <= i_cfg_wdata[DW-2:0];
                CFG_STEP_RATE: r_step_rate <= i_cfg_wdata[DW-2:0];
                CFG_DEAD_ZONE: r_dead_zone <= i_cfg_wdata[DW-2:0];
                default: ;
            endcase
        end
    end

    // The output register frees the sequencer to take the next word while
    // this result waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit && out_free) begin
            r_out_data <= drive;
        end
    end

    // No word is taken while reset is held.
    assign s_axis_tready = ctrl.accept && i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODW'(r_out_data);

endmodule

@@ tb/sv/pid_step_deadband_clamp_unit_tb.sv @@
// Self-checking testbench for pid_step_deadband_clamp_unit: directed and random words,
// with random register settings, checked against a Q16.16 PID predictor kept in the bench.
// Depends on psdc_pkg and the unit itself.
module pid_step_deadband_clamp_unit_tb;
    import psdc_pkg::*;

    localparam int  DW         = 32;
    localparam int  FB         = 16;
    localparam int  WDOG_LIMIT = 4000;
    localparam int  HOLD_LEN   = 300;
    localparam int  PHASES     = 10;
    localparam int  PHASE_LEN  = 93;
    localparam longint DATA_MAX  = 64'sd2147483647;
    localparam longint DATA_MIN  = -64'sd2147483648;
    localparam longint INTEG_MAX = (64'sd1 <<< 47) - 1;
    localparam longint INTEG_MIN = -(64'sd1 <<< 47);
    localparam logic [127:0] TERM_CAP = 128'd1 << 60;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [31:0]   m_axis_tdata;
    logic          i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DW-1:0] i_cfg_wdata   = '0;

    pid_step_deadband_clamp_unit #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Words waiting to be sent ({base_value, error_in}) and drive values still due.
    logic [63:0] pending_words[$];
    logic [31:0] drive_due[$];

    // Bench copy of the registers and the controller state.
    longint gp_m, gi_m, gd_m, omax_m, omin_m, dt_m, rate_m, dz_m;
    longint integ_m, last_err_m;

    int  mismatches    = 0;
    int  send_gap      = 0;
    int  recv_stall    = 0;
    int  hold_cnt      = 0;
    bit  hold_ask      = 1'b0;
    bit  no_idle       = 1'b0;
    bit  in_taken      = 1'b0;

    // (a*b) >> FB with truncation toward zero; magnitude capped at 2^60.
    function automatic longint q16_product(input longint a, input longint b);
        logic [127:0] ma, mb, prod;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = (ma * mb) >> FB;
        if (prod > TERM_CAP) prod = TERM_CAP;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic [31:0] predict_drive(input logic [31:0] err_w,
                                                  input logic [31:0] base_w);
        longint e, mag, deriv, acc;
        e   = longint'(signed'(err_w));
        mag = (e < 0) ? -e : e;
        if (mag <= dz_m) e = 0;
        deriv = q16_product(e - last_err_m, rate_m);
        if (deriv > DATA_MAX) deriv = DATA_MAX;
        if (deriv < DATA_MIN) deriv = DATA_MIN;
        acc = longint'(signed'(base_w)) + q16_product(gp_m, e)
            + q16_product(gi_m, integ_m) + q16_product(gd_m, deriv);
        // Upper bound first, so crossed bounds leave out_min.
        if (acc > omax_m) acc = omax_m;
        if (acc < omin_m) acc = omin_m;
        integ_m = integ_m + q16_product(dt_m, e);
        if (integ_m > INTEG_MAX) integ_m = INTEG_MAX;
        if (integ_m < INTEG_MIN) integ_m = INTEG_MIN;
        last_err_m = e;
        return acc[31:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_sample();
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4, 5: v = longint'($urandom_range(0, 524288)) - 262144;
            6: begin
                case ($urandom_range(0, 4))
                    0: v = DATA_MAX;
                    1: v = DATA_MIN;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            7: begin
                // Right at the edge of the deadband.
                v = dz_m + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = longint'($urandom_range(0, 65535)) - 32768;
        endcase
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return $urandom;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'(int'($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 262144);
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_GAIN_P:    gp_m   = longint'(signed'(val));
            CFG_GAIN_I:    gi_m   = longint'(signed'(val));
            CFG_GAIN_D:    gd_m   = longint'(signed'(val));
            CFG_OUT_MAX:   omax_m = longint'(signed'(val));
            CFG_OUT_MIN:   omin_m = longint'(signed'(val));
            CFG_STEP_TIME: dt_m   = longint'(val[30:0]);
            CFG_STEP_RATE: rate_m = longint'(val[30:0]);
            CFG_DEAD_ZONE: dz_m   = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic offer(input logic [31:0] err_w, input logic [31:0] base_w);
        pending_words.push_back({base_w, err_w});
    endtask

    // Returns once every queued word is sent and every drive value has come back.
    task automatic drain();
        while (pending_words.size() != 0 || s_axis_tvalid || drive_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_settings();
        logic [31:0] a, b;
        write_reg(CFG_GAIN_P, pick_gain());
        write_reg(CFG_GAIN_I, pick_gain());
        write_reg(CFG_GAIN_D, pick_gain());
        case ($urandom_range(0, 3))
            0: begin
                a = 32'h7FFF_FFFF;
                b = 32'h8000_0000;
            end
            1: begin
                a = $urandom;
                b = $urandom;
                if (signed'(a) < signed'(b)) {a, b} = {b, a};
            end
            2: begin
                // Crossed bounds.
                a = 32'(-int'($urandom_range(0, 327680)));
                b = $urandom_range(1, 327680);
            end
            default: begin
                a = $urandom_range(0, 655360);
                b = -a;
            end
        endcase
        write_reg(CFG_OUT_MAX, a);
        write_reg(CFG_OUT_MIN, b);
        write_reg(CFG_STEP_TIME, pick_period());
        write_reg(CFG_STEP_RATE, pick_period());
        case ($urandom_range(0, 3))
            0: write_reg(CFG_DEAD_ZONE, 32'h0);
            1: write_reg(CFG_DEAD_ZONE, $urandom);
            default: write_reg(CFG_DEAD_ZONE, $urandom_range(0, 65536));
        endcase
    endtask

    // Sender: a word is replaced only after it was taken.
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (pending_words.size() != 0) begin
                s_axis_tdata  <= pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_axis_tready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end else if (hold_ask) begin
            m_axis_tready <= 1'b0;
            hold_ask = 1'b0;
            hold_cnt = HOLD_LEN;
        end else if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall = recv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_stall = pick_gap();
        end
    end

    // Checker and predictor, both on the rising edge.
    always @(posedge i_clk) begin
        logic [31:0] want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (drive_due.size() == 0) begin
                    $display("%0t: drive_out word with none due: got %h", $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = drive_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: drive_out mismatch: expected %h got %h",
                                 $time, want, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                drive_due.push_back(predict_drive(s_axis_tdata[31:0], s_axis_tdata[63:32]));
        end
    end

    // Watchdog on cycles with no word moving on either side.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        gp_m = 0; gi_m = 0; gd_m = 0;
        omax_m = DATA_MAX; omin_m = DATA_MIN;
        dt_m = 65536; rate_m = 65536; dz_m = 0;
        integ_m = 0; last_err_m = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero gains, so the drive value is the base.
        offer(32'h0, 32'h0);
        offer(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer(32'h8000_0000, 32'h8000_0000);
        offer(32'hFFFF_FFFF, 32'h0001_0000);
        drain();

        // Moderate gains, a +/-100 clamp and a half-unit deadband.
        write_reg(CFG_GAIN_P, 32'h0001_0000);
        write_reg(CFG_GAIN_I, 32'h0000_8000);
        write_reg(CFG_GAIN_D, 32'h0000_4000);
        write_reg(CFG_OUT_MAX, 32'h0064_0000);
        write_reg(CFG_OUT_MIN, 32'hFF9C_0000);
        write_reg(CFG_STEP_TIME, 32'h0001_0000);
        write_reg(CFG_STEP_RATE, 32'h0002_0000);
        write_reg(CFG_DEAD_ZONE, 32'h0000_8000);
        offer(32'h0000_8000, 32'h0);
        offer(32'hFFFF_8000, 32'h0);
        offer(32'h0000_8001, 32'h0001_0000);
        offer(32'hFFFF_7FFF, 32'h0);
        offer(32'h0003_0000, 32'h0063_0000);
        offer(32'h7FFF_FFFF, 32'h0);
        offer(32'h8000_0000, 32'h0);
        offer(32'h0, 32'h8000_0000);
        offer(32'h0, 32'h7FFF_FFFF);
        drain();

        // Extreme gains and periods: saturated products, derivative and integral.
        write_reg(CFG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(CFG_GAIN_I, 32'h8000_0000);
        write_reg(CFG_GAIN_D, 32'h8000_0000);
        write_reg(CFG_OUT_MAX, 32'h7FFF_FFFF);
        write_reg(CFG_OUT_MIN, 32'h8000_0000);
        write_reg(CFG_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_DEAD_ZONE, 32'h0);
        repeat (3) offer(32'h7FFF_FFFF, 32'h0);
        repeat (3) offer(32'h8000_0000, 32'h8000_0000);
        drain();

        // Crossed bounds and the widest deadband; only the most negative error escapes it.
        write_reg(CFG_OUT_MAX, 32'hFFFB_0000);
        write_reg(CFG_OUT_MIN, 32'h0005_0000);
        write_reg(CFG_DEAD_ZONE, 32'h7FFF_FFFF);
        offer(32'h7FFF_FFFF, $urandom);
        offer(32'h8000_0000, $urandom);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            random_settings();
            no_idle = (p == 6);
            if (p == 3) hold_ask = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                if ($urandom_range(0, 3) == 0)
                    offer(pick_sample(), $urandom);
                else
                    offer(pick_sample(), pick_sample());
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && drive_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
